// ----- design/path_curvature_speed_profile_macros.svh -----
// Assertion macros used by the checker file.
`ifndef PATH_CURVATURE_SPEED_PROFILE_MACROS_SVH
`define PATH_CURVATURE_SPEED_PROFILE_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PCSP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define PCSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/pcsp_pkg.sv -----
// Shared types, constants and tables of the curvature speed profile block.
package pcsp_pkg;
   localparam logic [15:0] SPEED_MAX_RESET = 16'd2844;
   localparam logic [15:0] SPEED_MIN_RESET = 16'd356;
   localparam logic [19:0] CURV_LIMIT_RESET = 20'd10800;
   localparam int unsigned COORD_WIDTH_DEF = 24;

   localparam logic [1:0] CSR_SPEED_MAX = 2'd0;
   localparam logic [1:0] CSR_SPEED_MIN = 2'd1;
   localparam logic [1:0] CSR_CURV_LIMIT = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TOO_SHORT = 2'd1;
   localparam logic [1:0] ST_ZERO_LEN = 2'd2;

   localparam logic [30:0] PI_Q29 = 31'd1686629713;

   // Arithmetic unit operation codes.
   typedef enum logic [2:0] {
      OP_ATAN2,
      OP_SQRT,
      OP_DIV,
      OP_MUL
   } op_type;

   typedef struct packed {
      logic       start;
      op_type     op;
      logic [63:0] a;
      logic [63:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] res;
   } alu_rsp_type;

   // Main sequencer states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_SHORT,
      S_H_PREV,
      S_H_PREV_W,
      S_SEG,
      S_SEG_W,
      S_CURV,
      S_CURV_W,
      S_SQ_C,
      S_SQ_C_W,
      S_SQ_L,
      S_SQ_L_W,
      S_NUM,
      S_NUM_W,
      S_TDIV,
      S_TDIV_W,
      S_SPEED,
      S_EMIT,
      S_H_NEW,
      S_H_NEW_W,
      S_NEXT
   } state_type;

   function automatic logic [19:0] atan_step(input logic [3:0] i);
      case (i)
         4'd0: atan_step = 20'd131072;
         4'd1: atan_step = 20'd77376;
         4'd2: atan_step = 20'd40884;
         4'd3: atan_step = 20'd20753;
         4'd4: atan_step = 20'd10417;
         4'd5: atan_step = 20'd5213;
         4'd6: atan_step = 20'd2607;
         4'd7: atan_step = 20'd1304;
         4'd8: atan_step = 20'd652;
         4'd9: atan_step = 20'd326;
         4'd10: atan_step = 20'd163;
         4'd11: atan_step = 20'd81;
         4'd12: atan_step = 20'd41;
         4'd13: atan_step = 20'd20;
         4'd14: atan_step = 20'd10;
         default: atan_step = 20'd5;
      endcase
   endfunction
endpackage

// ----- design/pcsp_alu.sv -----
// Shared iterative unit: CORDIC atan2, square root, divide and multiply.
module pcsp_alu
   import pcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   output alu_rsp_type rsp
);
   typedef enum logic [2:0] {
      A_IDLE, A_NORM, A_CORDIC, A_SQRT, A_DIV, A_MUL, A_DONE
   } astate_type;

   astate_type  state_ff, state_in;
   op_type      op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [21:0] z_ff, z_in;
   logic [63:0] r_ff, r_in, v_ff, v_in, d_ff, d_in;
   logic [63:0] q_ff, q_in;
   logic        zero_ff, zero_in;

   logic signed [33:0] xs, ys, ax, ay, mx;
   logic [63:0] trial;
   logic [64:0] rem_sh;
   logic [31:0] mpart;
   logic [63:0] mprod;
   logic [21:0] zr;

   always_comb begin
      xs = x_ff >>> cnt_ff[3:0];
      ys = y_ff >>> cnt_ff[3:0];
      ax = x_ff[33] ? -x_ff : x_ff;
      ay = y_ff[33] ? -y_ff : y_ff;
      mx = (ax > ay) ? ax : ay;
      trial = r_ff | d_ff;
      rem_sh = {v_ff, q_ff[63]};
      mpart = cnt_ff[0] ? r_ff[63:32] : r_ff[31:0];
      mprod = {32'd0, mpart} * {32'd0, d_ff[31:0]};
      zr = z_ff + 22'sd8;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      r_in = r_ff;
      v_in = v_ff;
      d_in = d_ff;
      q_in = q_ff;
      zero_in = zero_ff;
      case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               op_in = cmd.op;
               cnt_in = '0;
               case (cmd.op)
                  OP_ATAN2: begin
                     // Rotate by pi when dx is negative.
                     zero_in = (cmd.a[25:0] == '0) && (cmd.b[25:0] == '0);
                     if (cmd.a[25]) begin
                        x_in = -{{8{cmd.a[25]}}, cmd.a[25:0]};
                        y_in = -{{8{cmd.b[25]}}, cmd.b[25:0]};
                        z_in = 22'sd524288;
                     end else begin
                        x_in = {{8{cmd.a[25]}}, cmd.a[25:0]};
                        y_in = {{8{cmd.b[25]}}, cmd.b[25:0]};
                        z_in = '0;
                     end
                     state_in = A_NORM;
                  end
                  OP_SQRT: begin
                     v_in = cmd.a;
                     r_in = '0;
                     d_in = 64'd1 << 52;
                     state_in = A_SQRT;
                  end
                  OP_DIV: begin
                     q_in = cmd.a;
                     d_in = cmd.b;
                     v_in = '0;
                     state_in = A_DIV;
                  end
                  default: begin
                     r_in = cmd.a;
                     d_in = cmd.b;
                     q_in = '0;
                     state_in = A_MUL;
                  end
               endcase
            end
         end
         A_NORM: begin
            if (zero_ff) begin
               q_in = '0;
               state_in = A_DONE;
            end else if (mx < 34'sd1073741824) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else begin
               state_in = A_CORDIC;
            end
         end
         A_CORDIC: begin
            if (!y_ff[33]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + $signed({2'b00, atan_step(cnt_ff[3:0])});
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - $signed({2'b00, atan_step(cnt_ff[3:0])});
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               state_in = A_DONE;
               q_in = 64'd0;
            end
         end
         A_SQRT: begin
            if (d_ff == '0) begin
               q_in = (v_ff > r_ff) ? r_ff + 64'd1 : r_ff;
               state_in = A_DONE;
            end else begin
               if (v_ff >= trial) begin
                  v_in = v_ff - trial;
                  r_in = (r_ff >> 1) | d_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               d_in = d_ff >> 2;
            end
         end
         A_DIV: begin
            // Restoring division, one quotient bit a cycle.
            if (rem_sh >= {1'b0, d_ff}) begin
               v_in = rem_sh[63:0] - d_ff;
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               v_in = rem_sh[63:0];
               q_in = {q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = A_DONE;
         end
         A_MUL: begin
            // Two 32x32 partial products: the low half of a first, then the high half.
            if (cnt_ff[0]) q_in = q_ff + {mprod[31:0], 32'd0};
            else q_in = mprod;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[0]) state_in = A_DONE;
         end
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      r_ff <= r_in;
      v_ff <= v_in;
      d_ff <= d_in;
      q_ff <= q_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      rsp.done = (state_ff == A_DONE);
      if (op_ff == OP_ATAN2 && !zero_ff) rsp.res = {{48{zr[19]}}, zr[19:4]};
      else rsp.res = q_ff;
   end
endmodule

// ----- design/path_curvature_speed_profile.sv -----
// Top level of the curvature-based speed profile of a streamed path.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata {y,x}, tlast point_last
//  rsp     | out       | rsp_tvalid/tready    | tdata, tuser status, tlast
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// Every atan2, square root, divide and multiply of a point goes through the one
// shared unit; a point releases up to three results.
// Synchronous active-high reset clears path state and loads the register reset values.
// req_tready is low while a point is being worked on; a stalled result holds
// the sequencer only once it has the next result to post, until it is taken.
module path_curvature_speed_profile
   import pcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [23:0] point_x, [47:24] point_y
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] point_index, [47:16] arc_length, [63:48] heading,
   // [95:64] curvature, [111:96] reference_speed
   output logic [111:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   localparam int unsigned COORD_WIDTH = COORD_WIDTH_DEF;
   localparam int unsigned DW = COORD_WIDTH + 2;

   state_type state_ff, state_in;
   logic [15:0] smax_ff, smin_ff;
   logic [19:0] climit_ff;

   logic signed [COORD_WIDTH-1:0] ox_ff, oy_ff, nx_ff, ny_ff, px_ff, py_ff;
   logic signed [COORD_WIDTH-1:0] ox_in, oy_in, nx_in, ny_in, px_in, py_in;
   logic [31:0] lo_ff, lo_in, ln_ff, ln_in;
   logic [15:0] ho_ff, ho_in, hf_ff, hf_in, seen_ff, seen_in;
   logic        last_ff, last_in;
   // Working values of the current point.
   logic [15:0] hp_ff, hp_in, hn_ff, hn_in;
   logic [31:0] seg_ff, seg_in, snew_ff, snew_in;
   logic signed [31:0] c_ff, c_in;
   logic [1:0]  st_ff, st_in;
   logic [63:0] c2_ff, c2_in, t_ff, t_in;
   logic [15:0] sp_ff, sp_in;
   // Which result is going out: 0 first point, 1 predecessor, 2 final.
   logic [1:0]  phase_ff, phase_in;
   logic        pend_ff, pend_in;
   logic [111:0] od_ff, od_in;
   logic [1:0]  ou_ff, ou_in;
   logic        ol_ff, ol_in;

   alu_cmd_type cmd;
   alu_rsp_type arsp;

   logic signed [DW-1:0] dx_o, dy_o, dx_n, dy_n;
   logic signed [15:0] dh;
   logic [16:0] dmag;
   logic dneg;
   logic [15:0] hsel_now, hsel_prev;
   logic [31:0] lsel;
   logic [31:0] cmag;
   logic [16:0] sdiff;
   logic sdneg;
   logic [32:0] asum;
   logic signed [17:0] u;
   logic [63:0] qround;

   pcsp_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (arsp)
   );

   always_comb begin
      dx_o = DW'(px_ff) - DW'(ox_ff);
      dy_o = DW'(py_ff) - DW'(oy_ff);
      dx_n = DW'(px_ff) - DW'(nx_ff);
      dy_n = DW'(py_ff) - DW'(ny_ff);
      // Curvature of the predecessor, or of the final point.
      hsel_now = (phase_ff == 2'd2) ? hn_ff : hp_ff;
      hsel_prev = (phase_ff == 2'd2) ? hp_ff : ho_ff;
      lsel = (phase_ff == 2'd2) ? seg_ff : lo_ff;
      dh = $signed(hsel_now - hsel_prev);
      dneg = dh[15] && (dh != -16'sd32768);
      dmag = dneg ? 17'(-dh) : ((dh == -16'sd32768) ? 17'd32768 : {1'b0, dh});
      cmag = c_ff[31] ? 32'(-c_ff) : c_ff;
      sdneg = smin_ff < smax_ff;
      sdiff = sdneg ? 17'(smax_ff - smin_ff) : 17'(smin_ff - smax_ff);
      // Arc length at the new point, from the segment the unit just returned.
      asum = {1'b0, ln_ff} + {1'b0, arsp.res[31:0]};
      u = sdneg ? $signed({2'b00, smax_ff}) - $signed({2'b00, t_ff[15:0]})
                : $signed({2'b00, smax_ff}) + $signed({2'b00, t_ff[15:0]});
      qround = arsp.res;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      ox_in = ox_ff; oy_in = oy_ff; nx_in = nx_ff; ny_in = ny_ff;
      px_in = px_ff; py_in = py_ff;
      lo_in = lo_ff; ln_in = ln_ff; ho_in = ho_ff; hf_in = hf_ff;
      seen_in = seen_ff; last_in = last_ff;
      hp_in = hp_ff; hn_in = hn_ff; seg_in = seg_ff; snew_in = snew_ff;
      c_in = c_ff; st_in = st_ff; c2_in = c2_ff; t_in = t_ff; sp_in = sp_ff;
      phase_in = phase_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               px_in = req_tdata[COORD_WIDTH-1:0];
               py_in = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
               last_in = req_tlast;
               if (seen_ff < 16'd2 && req_tlast) state_in = S_SHORT;
               else if (seen_ff == 16'd0) begin
                  nx_in = req_tdata[COORD_WIDTH-1:0];
                  ny_in = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                  ln_in = '0;
                  seen_in = 16'd1;
               end else if (seen_ff == 16'd1) state_in = S_SEG;
               else state_in = S_H_PREV;
            end
         end
         S_SHORT: begin
            if (!pend_ff) state_in = S_NEXT;
         end
         S_H_PREV: begin
            cmd.start = 1'b1;
            cmd.op = (seen_ff == 16'd1) ? OP_ATAN2 : OP_ATAN2;
            cmd.a = (seen_ff == 16'd1) ? 64'(dx_n) : 64'(dx_o);
            cmd.b = (seen_ff == 16'd1) ? 64'(dy_n) : 64'(dy_o);
            state_in = S_H_PREV_W;
         end
         S_H_PREV_W: begin
            if (arsp.done) begin
               if (seen_ff == 16'd1) begin
                  hf_in = arsp.res[15:0];
                  ho_in = arsp.res[15:0];
                  ox_in = nx_ff; oy_in = ny_ff;
                  nx_in = px_ff; ny_in = py_ff;
                  lo_in = seg_ff; ln_in = seg_ff;
                  seen_in = 16'd2;
                  state_in = S_IDLE;
               end else begin
                  hp_in = arsp.res[15:0];
                  state_in = S_SEG;
               end
            end
         end
         S_SEG: begin
            cmd.start = 1'b1;
            cmd.op = OP_SQRT;
            cmd.a = 64'(dx_n * dx_n) + 64'(dy_n * dy_n);
            state_in = S_SEG_W;
         end
         S_SEG_W: begin
            if (arsp.done) begin
               seg_in = arsp.res[31:0];
               if (seen_ff == 16'd1) state_in = S_H_PREV;
               else begin
                  phase_in = (seen_ff == 16'd2) ? 2'd0 : 2'd1;
                  snew_in = asum[32] ? 32'hFFFF_FFFF : asum[31:0];
                  state_in = S_CURV;
               end
            end
         end
         S_CURV: begin
            if (lsel == '0) begin
               st_in = ST_ZERO_LEN;
               c_in = dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               state_in = S_SQ_C;
            end else begin
               st_in = ST_OK;
               cmd.start = 1'b1;
               cmd.op = OP_DIV;
               cmd.a = 64'(dmag) * 64'(PI_Q29) + ({32'd0, lsel} << 19);
               cmd.b = {32'd0, lsel} << 20;
               state_in = S_CURV_W;
            end
         end
         S_CURV_W: begin
            if (arsp.done) begin
               if (dneg) c_in = (qround > 64'd2147483648) ? 32'sh8000_0000
                                                           : -$signed(qround[31:0]);
               else c_in = (qround > 64'd2147483647) ? 32'sh7FFF_FFFF
                                                      : $signed(qround[31:0]);
               state_in = S_SQ_C;
            end
         end
         S_SQ_C: begin
            if (cmag >= {12'd0, climit_ff}) begin
               sp_in = smin_ff;
               state_in = S_SPEED;
            end else begin
               cmd.start = 1'b1;
               cmd.op = OP_MUL;
               cmd.a = {32'd0, cmag};
               cmd.b = {32'd0, cmag};
               state_in = S_SQ_C_W;
            end
         end
         S_SQ_C_W: begin
            if (arsp.done) begin
               c2_in = arsp.res;
               state_in = S_SQ_L;
            end
         end
         S_SQ_L: begin
            cmd.start = 1'b1;
            cmd.op = OP_MUL;
            cmd.a = {44'd0, climit_ff};
            cmd.b = {44'd0, climit_ff};
            state_in = S_SQ_L_W;
         end
         S_SQ_L_W: begin
            if (arsp.done) begin
               t_in = arsp.res;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            // c^2 < 2^40, the difference < 2^17: split across two products.
            cmd.start = 1'b1;
            cmd.op = OP_MUL;
            cmd.a = c2_ff;
            cmd.b = {47'd0, sdiff};
            state_in = S_NUM_W;
         end
         S_NUM_W: begin
            if (arsp.done) begin
               c2_in = arsp.res + (t_ff >> 1);
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            cmd.start = 1'b1;
            cmd.op = OP_DIV;
            cmd.a = c2_ff;
            cmd.b = t_ff;
            state_in = S_TDIV_W;
         end
         S_TDIV_W: begin
            if (arsp.done) begin
               t_in = arsp.res;
               state_in = S_SPEED;
            end
         end
         S_SPEED: begin
            if (cmag < {12'd0, climit_ff}) begin
               if (t_ff > 64'd65535) sp_in = sdneg ? 16'd0 : 16'hFFFF;
               else if (u < 0) sp_in = '0;
               else if (u > 18'sd65535) sp_in = 16'hFFFF;
               else sp_in = u[15:0];
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!pend_ff) begin
               if (phase_ff == 2'd0) begin
                  phase_in = 2'd1;
                  state_in = S_EMIT;
               end else if (phase_ff == 2'd1 && last_ff) begin
                  phase_in = 2'd2;
                  state_in = S_H_NEW;
               end else state_in = S_NEXT;
            end
         end
         S_H_NEW: begin
            cmd.start = 1'b1;
            cmd.op = OP_ATAN2;
            cmd.a = 64'(dx_n);
            cmd.b = 64'(dy_n);
            state_in = S_H_NEW_W;
         end
         S_H_NEW_W: begin
            if (arsp.done) begin
               hn_in = arsp.res[15:0];
               state_in = S_CURV;
            end
         end
         S_NEXT: begin
            if (last_ff) begin
               ox_in = '0; oy_in = '0; nx_in = '0; ny_in = '0;
               lo_in = '0; ln_in = '0; ho_in = '0; hf_in = '0; seen_in = '0;
            end else begin
               ho_in = hp_ff;
               ox_in = nx_ff; oy_in = ny_ff;
               nx_in = px_ff; ny_in = py_ff;
               lo_in = seg_ff;
               ln_in = snew_ff;
               seen_in = (seen_ff == 16'hFFFF) ? 16'hFFFF : seen_ff + 16'd1;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register: load a result when the sequencer posts one.
   always_comb begin
      pend_in = pend_ff && !rsp_tready;
      od_in = od_ff;
      ou_in = ou_ff;
      ol_in = ol_ff;
      if (state_ff == S_SHORT && !pend_ff) begin
         pend_in = 1'b1;
         od_in = '0;
         ou_in = ST_TOO_SHORT;
         ol_in = 1'b1;
      end else if (state_ff == S_EMIT && !pend_ff) begin
         pend_in = 1'b1;
         ou_in = st_ff;
         ol_in = (phase_ff == 2'd2);
         case (phase_ff)
            2'd0: od_in = {sp_ff, c_ff, hf_ff, 32'd0, 16'd0};
            2'd1: od_in = {sp_ff, c_ff, hp_ff, ln_ff,
                           (seen_ff == 16'hFFFF) ? 16'hFFFF : seen_ff - 16'd1};
            default: od_in = {sp_ff, c_ff, hn_ff, snew_ff, seen_ff};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         smax_ff <= SPEED_MAX_RESET;
         smin_ff <= SPEED_MIN_RESET;
         climit_ff <= CURV_LIMIT_RESET;
         seen_ff <= '0;
         pend_ff <= 1'b0;
         ox_ff <= '0; oy_ff <= '0; nx_ff <= '0; ny_ff <= '0;
         lo_ff <= '0; ln_ff <= '0; ho_ff <= '0; hf_ff <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         ox_ff <= ox_in; oy_ff <= oy_in; nx_ff <= nx_in; ny_ff <= ny_in;
         lo_ff <= lo_in; ln_ff <= ln_in; ho_ff <= ho_in; hf_ff <= hf_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SPEED_MAX: smax_ff <= csr_wdata[15:0];
               CSR_SPEED_MIN: smin_ff <= csr_wdata[15:0];
               CSR_CURV_LIMIT: climit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      px_ff <= px_in; py_ff <= py_in; last_ff <= last_in;
      hp_ff <= hp_in; hn_ff <= hn_in; seg_ff <= seg_in; snew_ff <= snew_in;
      c_ff <= c_in; st_ff <= st_in; c2_ff <= c2_in; t_ff <= t_in; sp_ff <= sp_in;
      phase_ff <= phase_in;
      od_ff <= od_in; ou_ff <= ou_in; ol_ff <= ol_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = pend_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tuser = ou_ff;
   assign rsp_tlast = ol_ff;
endmodule

// ----- design/pcsp_checker.sv -----
// Port-level checker for the curvature speed profile, bound to the top level.
`include "path_curvature_speed_profile_macros.svh"
module pcsp_checker
   import pcsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   `PCSP_ASSERT_NEXT(a_busy_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "ready after final point")
   `PCSP_ASSERT_IMPLY(a_short_is_last, clock, reset, rsp_tvalid && rsp_tuser == ST_TOO_SHORT, rsp_tlast && rsp_tdata == '0, "too-short result malformed")
   `PCSP_ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, rsp_tuser <= ST_ZERO_LEN, "bad status")
   `PCSP_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
endmodule

bind path_curvature_speed_profile pcsp_checker u_pcsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/sv/path_curvature_speed_profile_tb.sv -----
// Self-checking testbench of the curvature-based speed profile of a streamed path.
module path_curvature_speed_profile_tb;
   import pcsp_pkg::*;

   // Index 3 maps to no register; a write to it must change nothing.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct {
      logic [15:0] index;
      logic [31:0] arc;
      logic [15:0] heading;
      logic [31:0] curv;
      logic [15:0] speed;
      logic [1:0]  status;
      logic        last;
   } profile_point_type;

   typedef struct {
      int  x;
      int  y;
      bit  last;
      bit  short_path;   // typed-in expectation: the path-too-short result
   } point_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en;
   logic [1:0]   csr_index;
   logic [19:0]  csr_wdata;
   logic         req_short_typed;

   path_curvature_speed_profile DUT (.*);

   // CORDIC step angles in units of pi/2^19
   int unsigned atan_angle [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                                    652, 326, 163, 81, 41, 20, 10, 5};

   // Predictor state: registers and the window of the last two points
   longint unsigned lim_speed_max, lim_speed_min, lim_curv;
   longint      win_older_x, win_older_y, win_newer_x, win_newer_y;
   longint unsigned seg_older_len, arc_at_newer;
   logic [15:0] head_older, head_first;
   int unsigned points_in_path;

   profile_point_type profile_queue[$];
   int errors = 0;
   int results_seen = 0;
   int points_sent = 0;
   int send_idle_pct, recv_stall_pct;

   function automatic logic [15:0] path_angle(longint dx, longint dy);
      longint x, y, z, m, xs, ys;
      if (dx == 0 && dy == 0) return 16'd0;
      x = dx; y = dy; z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = 524288;
      end
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      while (m < (64'sd1 <<< 30)) begin
         x = x * 2; y = y * 2; m = m * 2;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_angle[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_angle[i];
         end
      end
      return 16'((z + 8) >>> 4);
   endfunction

   // Rounded square root of dx^2+dy^2, ties up
   function automatic longint unsigned segment_len(longint dx, longint dy);
      longint unsigned v, r, b;
      v = longint'(dx * dx) + longint'(dy * dy);
      r = 0;
      b = 64'd1 << 50;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (v > r) r++;
      return r;
   endfunction

   function automatic longint bend(logic [15:0] h_now, logic [15:0] h_prev,
                                   longint unsigned len, output logic [1:0] st);
      logic signed [15:0] dw;
      longint d;
      longint unsigned mag, q, dv;
      dw = h_now - h_prev;
      d = dw;
      if (d == -32768) d = 32768;
      st = ST_OK;
      if (len == 0) begin
         st = ST_ZERO_LEN;
         return (d < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      mag = longint'((d < 0) ? -d : d) * 64'd1686629713;
      dv = len << 20;
      q = (mag + (dv >> 1)) / dv;
      if (d < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
      return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
   endfunction

   function automatic logic [15:0] speed_for(longint c);
      longint unsigned mag, c2, cm2, num, t;
      longint diff, u;
      mag = (c < 0) ? -c : c;
      if (mag >= lim_curv) return lim_speed_min[15:0];
      c2 = mag * mag;
      cm2 = lim_curv * lim_curv;
      diff = longint'(lim_speed_min) - longint'(lim_speed_max);
      num = longint'((diff < 0) ? -diff : diff) * c2;
      t = (num + cm2 / 2) / cm2;
      u = longint'(lim_speed_max) + ((diff < 0) ? -longint'(t) : longint'(t));
      if (u < 0) u = 0;
      if (u > 65535) u = 65535;
      return u[15:0];
   endfunction

   function automatic void push_point(longint unsigned idx, longint unsigned arc,
                                      logic [15:0] hd, longint c, logic [1:0] st, bit last);
      profile_point_type p;
      p.index = idx[15:0];
      p.arc = arc[31:0];
      p.heading = hd;
      p.curv = c[31:0];
      p.speed = speed_for(c);
      p.status = st;
      p.last = last;
      profile_queue.push_back(p);
   endfunction

   function automatic void clear_path();
      win_older_x = 0; win_older_y = 0; win_newer_x = 0; win_newer_y = 0;
      seg_older_len = 0; arc_at_newer = 0;
      head_older = 0; head_first = 0;
      points_in_path = 0;
   endfunction

   // Work out the results that one accepted point releases
   function automatic void predict_profile(longint px, longint py, bit last, bit typed);
      int unsigned n;
      longint unsigned seg, arc_new, sum;
      logic [15:0] h_prev, h_new;
      longint c_prev, c_new;
      logic [1:0] st, st2;
      profile_point_type p;
      n = points_in_path;
      if (n < 2) begin
         if (last) begin
            if (typed) begin
               p = '{16'd0, 32'd0, 16'd0, 32'd0, 16'd0, ST_TOO_SHORT, 1'b1};
               profile_queue.push_back(p);
            end else begin
               p = '{16'd0, 32'd0, 16'd0, 32'd0, 16'd0, ST_TOO_SHORT, 1'b1};
               profile_queue.push_back(p);
            end
            clear_path();
            return;
         end
         if (n == 1) begin
            seg = segment_len(px - win_newer_x, py - win_newer_y);
            head_first = path_angle(px - win_newer_x, py - win_newer_y);
            head_older = head_first;
            win_older_x = win_newer_x; win_older_y = win_newer_y;
            seg_older_len = seg;
            arc_at_newer = seg;
         end else begin
            arc_at_newer = 0;
         end
         win_newer_x = px; win_newer_y = py;
         points_in_path = n + 1;
         return;
      end
      h_prev = path_angle(px - win_older_x, py - win_older_y);
      c_prev = bend(h_prev, head_older, seg_older_len, st);
      seg = segment_len(px - win_newer_x, py - win_newer_y);
      sum = arc_at_newer + seg;
      arc_new = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
      // the first point borrows the curvature and status of the second
      if (n == 2) push_point(0, 0, head_first, c_prev, st, 0);
      push_point((n >= 65535) ? 65535 : n - 1, arc_at_newer, h_prev, c_prev, st, 0);
      if (last) begin
         h_new = path_angle(px - win_newer_x, py - win_newer_y);
         c_new = bend(h_new, h_prev, seg, st2);
         push_point(n, arc_new, h_new, c_new, st2, 1);
         clear_path();
         return;
      end
      head_older = h_prev;
      win_older_x = win_newer_x; win_older_y = win_newer_y;
      win_newer_x = px; win_newer_y = py;
      seg_older_len = seg;
      arc_at_newer = arc_new;
      points_in_path = (n >= 65535) ? 65535 : n + 1;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict on every accepted point transaction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_profile(longint'($signed(req_tdata[23:0])), longint'($signed(req_tdata[47:24])),
                         req_tlast, req_short_typed);
         points_sent++;
      end
   end

   // Randomly stall the result channel
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      profile_point_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (profile_queue.size() == 0) begin
            $error("unexpected result transaction: index %0d", rsp_tdata[15:0]);
            errors++;
         end else begin
            e = profile_queue.pop_front();
            if (rsp_tdata[15:0] !== e.index) begin
               $error("point_index: expected %0d, got %0d", e.index, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[47:16] !== e.arc) begin
               $error("arc_length: expected %0d, got %0d", e.arc, rsp_tdata[47:16]);
               errors++;
            end
            if (rsp_tdata[63:48] !== e.heading) begin
               $error("heading: expected %0d, got %0d", $signed(e.heading),
                      $signed(rsp_tdata[63:48]));
               errors++;
            end
            if (rsp_tdata[95:64] !== e.curv) begin
               $error("curvature: expected %0d, got %0d", $signed(e.curv),
                      $signed(rsp_tdata[95:64]));
               errors++;
            end
            if (rsp_tdata[111:96] !== e.speed) begin
               $error("reference_speed: expected %0d, got %0d", e.speed, rsp_tdata[111:96]);
               errors++;
            end
            if (rsp_tuser !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("result_last: expected %0d, got %0d", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: %0d results still expected", profile_queue.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Present one point and hold it until accepted; then maybe drop valid
   task automatic send_point(int x, int y, bit last, bit typed);
      req_tvalid <= 1'b1;
      req_tdata <= {y[23:0], x[23:0]};
      req_tlast <= last;
      req_short_typed <= typed;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Hold off until every expected result is in and the block has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (profile_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [19:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SPEED_MAX:  lim_speed_max = value[15:0];
         CSR_SPEED_MIN:  lim_speed_min = value[15:0];
         CSR_CURV_LIMIT: lim_curv = value;
         default: ;
      endcase
   endtask

   // Random paths: mostly well-formed with short hops, plus short paths,
   // repeated points and full-range jumps; the last path is cut to fit count
   task automatic random_paths(int count);
      int sent, len, x, y;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(99) < 10) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         if (len > count - sent) len = count - sent;
         x = $urandom_range(0, 32'hFFFFFF);
         y = $urandom_range(0, 32'hFFFFFF);
         x = (x << 8) >>> 8;
         y = (y << 8) >>> 8;
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
               0: ;   // repeat the point: zero-length segment
               1: begin
                  x = int'($urandom) >>> 8;
                  y = int'($urandom) >>> 8;
               end
               default: begin
                  x = x + $urandom_range(0, 4000) - 2000;
                  y = y + $urandom_range(0, 4000) - 2000;
               end
            endcase
            x = (x << 8) >>> 8;
            y = (y << 8) >>> 8;
            send_point(x, y, i == len - 1, 0);
            sent++;
         end
      end
   endtask

   point_row_type directed [21] = '{
      '{0, 0, 1, 1},
      '{100, 100, 0, 0}, '{200, 300, 1, 1},
      '{-8388608, -8388608, 0, 0}, '{8388607, 8388607, 0, 0},
      '{8388607, -8388608, 0, 0}, '{-8388608, 8388607, 1, 0},
      '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{256, 0, 0, 0}, '{256, 0, 1, 0},
      '{0, 0, 0, 0}, '{256, 0, 0, 0}, '{512, 0, 0, 0}, '{768, 0, 1, 0},
      '{0, 0, 0, 0}, '{1024, 0, 0, 0}, '{0, 0, 1, 0},
      '{0, 0, 0, 0}, '{-512, 256, 0, 0}, '{-1024, -256, 1, 0}
   };

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_short_typed = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_SPEED_MAX;
      csr_wdata = '0;
      lim_speed_max = SPEED_MAX_RESET;
      lim_speed_min = SPEED_MIN_RESET;
      lim_curv = CURV_LIMIT_RESET;
      clear_path();
      send_idle_pct = 27;
      recv_stall_pct = 87;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed points under reset register values
      foreach (directed[i])
         send_point(directed[i].x, directed[i].y, directed[i].last, directed[i].short_path);
      wait_idle();

      write_csr(CSR_SPEED_MAX, 20'd3000);
      write_csr(CSR_SPEED_MIN, 20'd200);
      write_csr(CSR_CURV_LIMIT, 20'd20000);
      random_paths(35);
      wait_idle();

      // swap the idling roles
      send_idle_pct = 87;
      recv_stall_pct = 27;
      write_csr(CSR_SPEED_MAX, 20'd65535);
      write_csr(CSR_SPEED_MIN, 20'd0);
      write_csr(CSR_CURV_LIMIT, 20'hFFFFF);
      random_paths(35);
      wait_idle();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_SPEED_MAX, 20'd0);
      write_csr(CSR_SPEED_MIN, 20'd65535);
      write_csr(CSR_CURV_LIMIT, 20'd1);
      random_paths(40);
      wait_idle();

      // zero limit forces the minimum speed; the unmapped index is ignored
      write_csr(CSR_CURV_LIMIT, 20'd0);
      write_csr(CSR_SPEED_MIN, 20'd500);
      write_csr(CSR_UNMAPPED, 20'hABCDE);
      random_paths(40);
      wait_idle();

      $display("covered %0d points and %0d results over five register settings",
               points_sent, results_seen);
      $display("three idling modes, short paths, zero-length segments and extreme coordinates");
      if (errors == 0 && profile_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+design
design/pcsp_pkg.sv
design/pcsp_alu.sv
design/path_curvature_speed_profile.sv
design/pcsp_checker.sv
tb/sv/path_curvature_speed_profile_tb.sv
